@@ sv/rlf_pkg.sv @@
// ----------------------------------------------------------------------------
// rlf_pkg
// Shared constants for the Roche-lobe fill filter: pipeline latencies, the
// log10 scale factor and the two sets of cubic fit coefficients.
// ----------------------------------------------------------------------------
package rlf_pkg;

    localparam int unsigned LOG_LAT  = 17;
    localparam int unsigned LOBE_LAT = 7;

    localparam int unsigned LOG_W = 20;
    localparam int unsigned RAD_W = 16;

    // Scale from log2 (16 fraction bits) to log10 q (12 fraction bits), times 2^32.
    localparam logic signed [28:0] LOG10_SCALE_K = 29'sd123958128;

    // Fit selection threshold, log10 q = -1 in Q4.12.
    localparam logic signed [15:0] FIT_SPLIT = -16'sd4096;

    typedef logic signed [13:0] t_coef;

    localparam t_coef HI_C0 = 14'sd6188;
    localparam t_coef HI_C1 = 14'sd3317;
    localparam t_coef HI_C2 = 14'sd301;
    localparam t_coef HI_C3 = 14'sd373;
    localparam t_coef LO_C0 = 14'sd6178;
    localparam t_coef LO_C1 = 14'sd3491;
    localparam t_coef LO_C2 = -14'sd131;
    localparam t_coef LO_C3 = 14'sd108;

endpackage

@@ sv/rlf_log2.sv @@
// ----------------------------------------------------------------------------
// rlf_log2
// Pipelined log2 of a 16-bit value with 16 fraction bits, one bit of the
// fraction per stage by squaring the normalized mantissa.
// ----------------------------------------------------------------------------
module rlf_log2
    import rlf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [RAD_W-1:0]   i_x,
    output logic [LOG_W-1:0]   o_log
);

    logic [3:0]  n_n;
    logic [31:0] n_m;

    logic [31:0] r_m [0:16];
    logic [3:0]  r_n [0:16];
    logic [15:0] r_f [0:16];

    always_comb begin
        n_n = '0;
        for (int i = 1; i < RAD_W; i++) begin
            if (i_x[i]) begin
                n_n = 4'(i);
            end
        end
        n_m = {16'b0, i_x} << (5'd31 - {1'b0, n_n});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0] <= n_m;
            r_n[0] <= n_n;
            r_f[0] <= '0;
        end
    end

    for (genvar k = 0; k < 16; k++) begin : g_step
        logic [63:0] sq;
        logic [32:0] t;
        logic [31:0] n_mk;

        always_comb begin
            sq   = 64'(r_m[k]) * 64'(r_m[k]);
            t    = sq[63:31];
            n_mk = t[32] ? t[32:1] : t[31:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[k+1] <= n_mk;
                r_n[k+1] <= r_n[k];
                r_f[k+1] <= {r_f[k][14:0], t[32]};
            end
        end
    end

    assign o_log = {r_n[16], r_f[16]};

endmodule

@@ sv/rlf_lobe.sv @@
// ----------------------------------------------------------------------------
// rlf_lobe
// Pipelined lobe test for one star: log10 q from the log2 difference, the
// selected cubic fit for the Roche radius, and the radius compare.
// ----------------------------------------------------------------------------
module rlf_lobe
    import rlf_pkg::*;
#(
    parameter int RADIUS_FRAC_BITS = 16
)
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [LOG_W-1:0] i_la,
    input  logic [LOG_W-1:0] i_lb,
    input  logic [RAD_W-1:0] i_own,
    output logic             o_fill
);

    localparam int CW = 32 + RADIUS_FRAC_BITS;

    logic [RAD_W-1:0] r_own [0:5];

    logic signed [20:0] d;
    logic signed [49:0] r_prod;
    logic signed [49:0] rnd1;
    logic signed [17:0] lv;
    logic signed [15:0] n_l, r_l1, r_l2, r_l3;
    logic               r_sel2, r_sel3;
    logic signed [31:0] r_l2sq, r_l2sq3;
    logic signed [47:0] r_l3cu;
    logic signed [29:0] r_t1;
    logic signed [45:0] r_t2;
    logic signed [63:0] r_part, r_t3;
    logic signed [63:0] rnd2;
    logic signed [27:0] rv;
    logic signed [15:0] n_ra, r_ra;
    logic signed [CW-1:0] lhs, rhs;
    logic               r_fill;
    t_coef c0, c1, c2, c3;

    always_comb begin
        d    = $signed({1'b0, i_la}) - $signed({1'b0, i_lb});
        rnd1 = r_prod + 50'sd2147483648;
        lv   = rnd1[49:32];
        if (lv < -18'sd32768) begin
            n_l = -16'sd32768;
        end else if (lv > 18'sd32767) begin
            n_l = 16'sd32767;
        end else begin
            n_l = lv[15:0];
        end
        c0 = r_sel3 ? HI_C0 : LO_C0;
        c1 = r_sel2 ? HI_C1 : LO_C1;
        c2 = r_sel2 ? HI_C2 : LO_C2;
        c3 = r_sel3 ? HI_C3 : LO_C3;
        rnd2 = r_part + r_t3 + (64'sd1 <<< 35);
        rv   = rnd2[63:36];
        if (rv < -28'sd32768) begin
            n_ra = -16'sd32768;
        end else if (rv > 28'sd32767) begin
            n_ra = 16'sd32767;
        end else begin
            n_ra = rv[15:0];
        end
        lhs = $signed(CW'(r_own[5]) <<< 14);
        rhs = CW'(r_ra) <<< RADIUS_FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_own[0] <= i_own;
            for (int i = 1; i < 6; i++) begin
                r_own[i] <= r_own[i-1];
            end
            r_prod  <= 50'(d) * 50'(LOG10_SCALE_K);
            r_l1    <= n_l;
            r_l2    <= r_l1;
            r_sel2  <= r_l1 > FIT_SPLIT;
            r_l2sq  <= 32'(r_l1) * 32'(r_l1);
            r_l3    <= r_l2;
            r_sel3  <= r_sel2;
            r_l3cu  <= 48'(r_l2sq) * 48'(r_l2);
            r_t1    <= 30'(c1) * 30'(r_l2);
            r_t2    <= 46'(c2) * 46'(r_l2sq);
            r_t3    <= 64'(c3) * 64'(r_l3cu);
            r_part  <= (64'(c0) <<< 36) + (64'(r_t1) <<< 24) + (64'(r_t2) <<< 12);
            r_ra    <= n_ra;
            r_fill  <= lhs >= rhs;
        end
    end

    assign o_fill = r_fill;

endmodule

@@ sv/roche_lobe_fill_filter.sv @@
// ----------------------------------------------------------------------------
// roche_lobe_fill_filter
// Counts how many of a binary's two stars fill their Roche lobe and flags the
// record to keep when no radius is zero and the count matches the configured count.
//
//   channel  dir  handshake           payload
//   s        in   i_s_tvalid/o_s_tready  i_s_tdata: radius_large, radius_small
//   m        out  o_m_tvalid/i_m_tready  o_m_tdata: keep, count; o_m_tuser: bad
//   cfg      in   i_cfg_we             i_cfg_wdata: wanted_filled_lobes
//
// One request per cycle while the output does not stall; each passes 25
// register stages, 17 in the log2 squaring pipeline, 7 in the fit pipeline
// and the output register. The whole pipeline advances together; a stall
// at the output holds every stage. Reset is synchronous and clears the
// valid bits and the register.
// ----------------------------------------------------------------------------
module roche_lobe_fill_filter
    import rlf_pkg::*;
#(
    parameter int RADIUS_FRAC_BITS = 16
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] radius_large, [31:16] radius_small
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [0] keep_record, [2:1] filled_count, zero fill
    output logic        o_m_tuser,   // [0] bad_radius
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata
);

    localparam int DLY = LOG_LAT + LOBE_LAT;

    logic             en;
    logic [1:0]       r_wanted;
    logic             r_vld [0:DLY-1];
    logic             r_bad [0:DLY-1];
    logic [RAD_W-1:0] r_rl [0:LOG_LAT-1];
    logic [RAD_W-1:0] r_rs [0:LOG_LAT-1];
    logic [LOG_W-1:0] log_l, log_s;
    logic             fill_l, fill_s;
    logic [1:0]       n_count;
    logic             r_out_vld, r_keep, r_out_bad;
    logic [1:0]       r_count;

    assign en         = i_m_tready || !r_out_vld;
    assign o_s_tready = en;

    rlf_log2 u_log_l (.i_clk(i_clk), .i_en(en), .i_x(i_s_tdata[15:0]), .o_log(log_l));
    rlf_log2 u_log_s (.i_clk(i_clk), .i_en(en), .i_x(i_s_tdata[31:16]), .o_log(log_s));

    rlf_lobe #(.RADIUS_FRAC_BITS(RADIUS_FRAC_BITS)) u_lobe_l (
        .i_clk(i_clk), .i_en(en), .i_la(log_l), .i_lb(log_s),
        .i_own(r_rl[LOG_LAT-1]), .o_fill(fill_l)
    );
    rlf_lobe #(.RADIUS_FRAC_BITS(RADIUS_FRAC_BITS)) u_lobe_s (
        .i_clk(i_clk), .i_en(en), .i_la(log_s), .i_lb(log_l),
        .i_own(r_rs[LOG_LAT-1]), .o_fill(fill_s)
    );

    assign n_count = r_bad[DLY-1] ? 2'd0 : ({1'b0, fill_l} + {1'b0, fill_s});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted  <= '0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < DLY; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                r_wanted <= i_cfg_wdata;
            end
            if (en) begin
                r_vld[0] <= i_s_tvalid;
                for (int i = 1; i < DLY; i++) begin
                    r_vld[i] <= r_vld[i-1];
                end
                r_out_vld <= r_vld[DLY-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bad[0] <= (i_s_tdata[15:0] == '0) || (i_s_tdata[31:16] == '0);
            for (int i = 1; i < DLY; i++) begin
                r_bad[i] <= r_bad[i-1];
            end
            r_rl[0] <= i_s_tdata[15:0];
            r_rs[0] <= i_s_tdata[31:16];
            for (int i = 1; i < LOG_LAT; i++) begin
                r_rl[i] <= r_rl[i-1];
                r_rs[i] <= r_rs[i-1];
            end
            r_count   <= n_count;
            r_out_bad <= r_bad[DLY-1];
            r_keep    <= !r_bad[DLY-1] && (n_count == r_wanted);
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {5'b0, r_count, r_keep};
    assign o_m_tuser  = r_out_bad;

    a_bad_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_bad |-> !r_keep && r_count == 2'd0)
        else $error("bad radius result not cleared");
    a_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_count != 2'd3)
        else $error("filled count out of range");
    a_stall_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_m_tready |-> !o_s_tready)
        else $error("input taken during output stall");
    a_tail_moves : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_vld[DLY-1] |=> r_out_vld)
        else $error("pipeline result dropped");

endmodule
